FILE: hw/rtl/jsu_pkg.sv
// ============================================================================
// jsu_pkg: shared types, codes and helpers
// Byte and result item types, escape character codes and UTF-8 encoding.
// ============================================================================
`default_nettype none

package jsu_pkg;

    // Character codes
    localparam logic [7:0] CH_BSL = 8'h5C;  // backslash
    localparam logic [7:0] CH_U   = 8'h75;  // 'u'
    localparam logic [7:0] CH_N   = 8'h6E;
    localparam logic [7:0] CH_R   = 8'h72;
    localparam logic [7:0] CH_T   = 8'h74;
    localparam logic [7:0] CH_B   = 8'h62;
    localparam logic [7:0] CH_F   = 8'h66;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_FF  = 8'h0C;

    // Upper six bits of high (D800..DBFF) and low (DC00..DFFF) surrogates
    localparam logic [5:0] SUR_HI_TAG = 6'b110110;
    localparam logic [5:0] SUR_LO_TAG = 6'b110111;

    localparam logic [20:0] SUP_BASE = 21'h10000;

    localparam int MAX_RES = 8;

    typedef enum logic [2:0] {
        PH_PLAIN,
        PH_ESC,
        PH_HEX1,
        PH_HI_WAIT,
        PH_HI_ESC,
        PH_HEX2
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
    } t_out_item;

    // Ordered list of result bytes for one request
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [3:0]              cnt;
    } t_blist;

    typedef struct packed {
        t_blist list;
        logic   eos;
    } t_result;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      len;
    } t_utf8;

    // {valid, value} of an ASCII hex digit of either case
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic t_utf8 utf8_enc(input logic [20:0] cp);
        t_utf8 e;
        e = '0;
        if (cp <= 21'h7F) begin
            e.b[0] = cp[7:0];
            e.len  = 3'd1;
        end else if (cp <= 21'h7FF) begin
            e.b[0] = 8'hC0 | {3'b000, cp[10:6]};
            e.b[1] = 8'h80 | {2'b00, cp[5:0]};
            e.len  = 3'd2;
        end else if (cp <= 21'hFFFF) begin
            e.b[0] = 8'hE0 | {4'b0000, cp[15:12]};
            e.b[1] = 8'h80 | {2'b00, cp[11:6]};
            e.b[2] = 8'h80 | {2'b00, cp[5:0]};
            e.len  = 3'd3;
        end else begin
            e.b[0] = 8'hF0 | {5'b00000, cp[20:18]};
            e.b[1] = 8'h80 | {2'b00, cp[17:12]};
            e.b[2] = 8'h80 | {2'b00, cp[11:6]};
            e.b[3] = 8'h80 | {2'b00, cp[5:0]};
            e.len  = 3'd4;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/jsu_decode.sv
// ============================================================================
// jsu_decode: escape decoder
// Holds the escape state and turns one request into its ordered result bytes.
// ============================================================================
`default_nettype none

module jsu_decode (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire jsu_pkg::t_in_item i_item,
    output jsu_pkg::t_result       o_res
);

    jsu_pkg::t_phase r_phase, n_phase;
    logic [2:0]      r_dc, n_dc;
    logic [15:0]     r_acc, n_acc;
    logic [15:0]     r_hs, n_hs;
    logic [3:0][7:0] r_held;
    logic            n_held_we;
    logic [1:0]      n_held_idx;

    function automatic jsu_pkg::t_blist put(input jsu_pkg::t_blist l, input logic [7:0] c);
        jsu_pkg::t_blist r;
        r = l;
        if (l.cnt < 4'(jsu_pkg::MAX_RES)) begin
            r.bytes[l.cnt[2:0]] = c;
            r.cnt = l.cnt + 4'd1;
        end
        return r;
    endfunction

    function automatic jsu_pkg::t_blist put_cp(input jsu_pkg::t_blist l,
                                               input logic [20:0]    cp);
        jsu_pkg::t_blist r;
        jsu_pkg::t_utf8  e;
        r = l;
        e = jsu_pkg::utf8_enc(cp);
        for (int k = 0; k < 4; k++) begin
            if (k < int'(e.len)) begin
                r = put(r, e.b[k]);
            end
        end
        return r;
    endfunction

    function automatic jsu_pkg::t_blist put_held(input jsu_pkg::t_blist l,
                                                 input logic [3:0][7:0] hd,
                                                 input logic [2:0] cnt);
        jsu_pkg::t_blist r;
        r = l;
        for (int k = 0; k < 4; k++) begin
            if (k < int'(cnt)) begin
                r = put(r, hd[k]);
            end
        end
        return r;
    endfunction

    always_comb begin
        jsu_pkg::t_blist lst;
        jsu_pkg::t_phase ph;
        logic [2:0]      dc;
        logic [15:0]     acc;
        logic [15:0]     hs;
        logic [3:0][7:0] hd;
        logic            done;
        logic [4:0]      hx;
        logic [7:0]      c;

        lst        = '0;
        ph         = r_phase;
        dc         = r_dc;
        acc        = r_acc;
        hs         = r_hs;
        hd         = r_held;
        done       = 1'b0;
        c          = i_item.in_byte;
        hx         = jsu_pkg::hex_val(c);
        n_held_we  = 1'b0;
        n_held_idx = r_dc[1:0];

        // First pass: states that may give up and hand the byte on
        unique case (ph)
            jsu_pkg::PH_HEX1: begin
                if (!hx[4]) begin
                    lst = put_held(lst, hd, dc);
                    dc  = 3'd0;
                    acc = 16'd0;
                    ph  = jsu_pkg::PH_PLAIN;
                end
            end
            jsu_pkg::PH_HI_WAIT: begin
                if (c == jsu_pkg::CH_BSL) begin
                    ph   = jsu_pkg::PH_HI_ESC;
                    done = 1'b1;
                end else begin
                    lst = put_cp(lst, {5'd0, hs});
                    ph  = jsu_pkg::PH_PLAIN;
                end
            end
            jsu_pkg::PH_HI_ESC: begin
                if (c == jsu_pkg::CH_U) begin
                    ph   = jsu_pkg::PH_HEX2;
                    dc   = 3'd0;
                    acc  = 16'd0;
                    done = 1'b1;
                end else begin
                    lst = put_cp(lst, {5'd0, hs});
                    ph  = jsu_pkg::PH_ESC;
                end
            end
            jsu_pkg::PH_HEX2: begin
                if (!hx[4]) begin
                    lst = put_cp(lst, {5'd0, hs});
                    lst = put_held(lst, hd, dc);
                    dc  = 3'd0;
                    acc = 16'd0;
                    ph  = jsu_pkg::PH_PLAIN;
                end
            end
            default: begin
            end
        endcase

        // Second pass: consume the byte
        if (!done) begin
            unique case (ph)
                jsu_pkg::PH_ESC: begin
                    ph = jsu_pkg::PH_PLAIN;
                    unique case (c)
                        jsu_pkg::CH_N: lst = put(lst, jsu_pkg::CH_LF);
                        jsu_pkg::CH_R: lst = put(lst, jsu_pkg::CH_CR);
                        jsu_pkg::CH_T: lst = put(lst, jsu_pkg::CH_TAB);
                        jsu_pkg::CH_B: lst = put(lst, jsu_pkg::CH_BS);
                        jsu_pkg::CH_F: lst = put(lst, jsu_pkg::CH_FF);
                        jsu_pkg::CH_U: begin
                            ph  = jsu_pkg::PH_HEX1;
                            dc  = 3'd0;
                            acc = 16'd0;
                        end
                        default: lst = put(lst, c);
                    endcase
                end
                jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
                    // byte is a hex digit here, the first pass caught the rest
                    n_held_we  = 1'b1;
                    n_held_idx = dc[1:0];
                    hd[dc[1:0]] = c;
                    acc = {acc[11:0], hx[3:0]};
                    dc  = dc + 3'd1;
                    if (dc == 3'd4) begin
                        dc = 3'd0;
                        if (ph == jsu_pkg::PH_HEX2 && acc[15:10] == jsu_pkg::SUR_LO_TAG) begin
                            lst = put_cp(lst, jsu_pkg::SUP_BASE + 21'({hs[9:0], acc[9:0]}));
                            ph  = jsu_pkg::PH_PLAIN;
                        end else begin
                            if (ph == jsu_pkg::PH_HEX2) begin
                                lst = put_cp(lst, {5'd0, hs});
                            end
                            if (acc[15:10] == jsu_pkg::SUR_HI_TAG) begin
                                hs = acc;
                                ph = jsu_pkg::PH_HI_WAIT;
                            end else begin
                                lst = put_cp(lst, {5'd0, acc});
                                ph  = jsu_pkg::PH_PLAIN;
                            end
                        end
                        acc = 16'd0;
                    end
                end
                default: begin
                    if (c == jsu_pkg::CH_BSL) begin
                        ph = jsu_pkg::PH_ESC;
                    end else begin
                        ph  = jsu_pkg::PH_PLAIN;
                        lst = put(lst, c);
                    end
                end
            endcase
        end

        // End of string: flush held hex digits and a waiting high surrogate
        if (i_item.end_of_string) begin
            unique case (ph)
                jsu_pkg::PH_HEX1: lst = put_held(lst, hd, dc);
                jsu_pkg::PH_HI_WAIT, jsu_pkg::PH_HI_ESC: lst = put_cp(lst, {5'd0, hs});
                jsu_pkg::PH_HEX2: begin
                    lst = put_cp(lst, {5'd0, hs});
                    lst = put_held(lst, hd, dc);
                end
                default: begin
                end
            endcase
            ph  = jsu_pkg::PH_PLAIN;
            dc  = 3'd0;
            acc = 16'd0;
            hs  = 16'd0;
        end

        n_phase   = ph;
        n_dc      = dc;
        n_acc     = acc;
        n_hs      = hs;
        o_res.list = lst;
        o_res.eos  = i_item.end_of_string;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= jsu_pkg::PH_PLAIN;
            r_dc    <= 3'd0;
            r_acc   <= 16'd0;
            r_hs    <= 16'd0;
        end else if (i_load) begin
            r_phase <= n_phase;
            r_dc    <= n_dc;
            r_acc   <= n_acc;
            r_hs    <= n_hs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && n_held_we) begin
            r_held[n_held_idx] <= i_item.in_byte;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/jsu_outbuf.sv
// ============================================================================
// jsu_outbuf: result register and replay
// Holds one request's result bytes and hands out one per cycle unless stalled.
// ============================================================================
`default_nettype none

module jsu_outbuf (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire jsu_pkg::t_result   i_res,
    output logic                    o_free,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output jsu_pkg::t_out_item      o_data
);

    logic [jsu_pkg::MAX_RES-1:0][7:0] r_buf;
    logic [3:0]                       r_rem;
    logic [2:0]                       r_head;
    logic                             r_eos;
    logic                             r_bare;
    logic                             out_acc;

    assign o_valid = (r_rem != 4'd0);
    assign out_acc = o_valid && !i_stall;
    assign o_free  = (r_rem == 4'd0) || (r_rem == 4'd1 && out_acc);

    assign o_data.out_byte   = r_bare ? 8'h00 : r_buf[r_head];
    assign o_data.byte_valid = !r_bare;
    assign o_data.last       = r_eos && (r_rem == 4'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= 4'd0;
            r_head <= 3'd0;
            r_eos  <= 1'b0;
            r_bare <= 1'b0;
        end else if (i_load) begin
            r_head <= 3'd0;
            r_eos  <= i_res.eos;
            // end of string with nothing emitted still yields a bare marker
            r_bare <= i_res.eos && (i_res.list.cnt == 4'd0);
            r_rem  <= (i_res.eos && i_res.list.cnt == 4'd0) ? 4'd1 : i_res.list.cnt;
        end else if (out_acc) begin
            r_head <= r_head + 3'd1;
            r_rem  <= r_rem - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_res.list.bytes;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/json_string_unescape_utf8.sv
// Path: a request's first result passes the input register, then the result
// register, before it reaches the output; a busy result register stalls it.
// Throughput: one request per cycle while each yields at most one result and
// the output is not stalled; a request with several results (up to 8) holds
// the result register while it hands them out, and that replay sets the rate.
// Reset: synchronous, active low; clears the pipeline and the escape state.
// ============================================================================
// json_string_unescape_utf8: JSON string body unescaper
// Decodes backslash and \u escapes of a byte stream into UTF-8 bytes.
// ============================================================================
`default_nettype none

module json_string_unescape_utf8 (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire jsu_pkg::t_in_item  i_data,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output jsu_pkg::t_out_item      o_data
);

    logic              r_in_vld;
    jsu_pkg::t_in_item r_in_data;
    logic              res_free;
    logic              load;
    logic              in_acc;
    jsu_pkg::t_result  res;

    assign load    = r_in_vld && res_free;
    assign o_stall = r_in_vld && !res_free;
    assign in_acc  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (load) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_data <= i_data;
        end
    end

    jsu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_item  (r_in_data),
        .o_res   (res)
    );

    jsu_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_res   (res),
        .o_free  (res_free),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/jsu_checker.sv
// ============================================================================
// jsu_checker: port-level checks
// Watches the top-level ports of the unescaper over time.
// ============================================================================
`default_nettype none

module jsu_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_stall,
    input wire jsu_pkg::t_in_item  i_data,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire jsu_pkg::t_out_item o_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // Input backs up only behind a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty result register");

    // A bare marker is always the final, empty result
    a_bare_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.byte_valid |-> o_data.last && o_data.out_byte == 8'h00)
        else $error("bare result without last or with a byte");

    // Nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_valid && !o_stall)
        else $error("output active after reset");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);

`default_nettype wire
